[hdl/watchdog_prescaler_search_defines.svh]
// Assertion macros used by the watchdog prescaler search RTL.
`ifndef WATCHDOG_PRESCALER_SEARCH_DEFINES_SVH
`define WATCHDOG_PRESCALER_SEARCH_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define WPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define WPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/wps_pkg.sv]
package wps_pkg;

  localparam int unsigned NumDividers = 8;
  localparam int unsigned NumPeriods  = 4;
  localparam int unsigned NumPairs    = NumDividers * NumPeriods;
  localparam int unsigned OrderW      = $clog2(NumPairs);

  // All dividers and periods are powers of two, so every numerator is
  // 1000 shifted left by the sum of the two exponents (at most 29).
  localparam int unsigned MaxShift = 29;
  localparam int unsigned ShiftW   = $clog2(MaxShift + 1);
  localparam int unsigned MsW      = 10;
  localparam logic [MsW-1:0] MsPerSecond = 10'd1000;
  // Numerator bits: the ten bits of 1000 followed by the shift zeros.
  localparam int unsigned NumBits  = MsW + MaxShift;
  localparam int unsigned StepW    = $clog2(NumBits + 1);

  localparam int unsigned DataW    = 32;
  localparam int unsigned DividerW = 14;
  localparam int unsigned PeriodW  = 17;

  localparam logic [3:0] DividerLog [NumDividers] = '{
    4'd2, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd13
  };
  localparam logic [4:0] PeriodLog [NumPeriods] = '{5'd8, 5'd12, 5'd14, 5'd16};

  typedef struct packed {
    logic load;
    logic step;
    logic num_bit;
  } div_ctrl_t;

  typedef struct packed {
    logic              clear;
    logic              check;
    logic [OrderW-1:0] order;
  } sel_ctrl_t;

  typedef struct packed {
    logic              hit;
    logic [OrderW-1:0] order;
  } pair_hit_t;

  function automatic logic [ShiftW-1:0] pair_shift(input logic [OrderW-1:0] order);
    logic [ShiftW-1:0] s;
    s = ShiftW'(DividerLog[order[OrderW-1:2]]) + ShiftW'(PeriodLog[order[1:0]]);
    return s;
  endfunction

  // First pair in search order whose numerator uses the given shift.
  function automatic pair_hit_t first_pair(input logic [ShiftW-1:0] k);
    pair_hit_t r;
    r = '0;
    for (int o = 0; o < NumPairs; o++) begin
      if (!r.hit && pair_shift(OrderW'(o)) == k) begin
        r.hit   = 1'b1;
        r.order = OrderW'(o);
      end
    end
    return r;
  endfunction

  function automatic logic [DividerW-1:0] divider_of(input logic [OrderW-1:0] order);
    return DividerW'(1) << DividerLog[order[OrderW-1:2]];
  endfunction

  function automatic logic [PeriodW-1:0] period_of(input logic [OrderW-1:0] order);
    return PeriodW'(1) << PeriodLog[order[1:0]];
  endfunction

endpackage

[hdl/wps_div_unit.sv]
module wps_div_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  wps_pkg::div_ctrl_t       ctrl_i,
  input  logic [wps_pkg::DataW-1:0] divisor_i,
  output logic [wps_pkg::DataW-1:0] quotient_o
);
  import wps_pkg::*;

  logic [DataW-1:0] divisor_q;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic             ovf_q, ovf_d;
  logic [DataW:0]   shifted;
  logic [DataW:0]   diff;
  logic             ge;

  // One restoring long-division step per cycle while step is set. The partial quotient after
  // each step is the floor of the numerator prefix divided by the divisor.
  always_comb begin
    shifted = {rem_q, ctrl_i.num_bit};
    diff    = shifted - {1'b0, divisor_q};
    ge      = (shifted >= {1'b0, divisor_q});
    rem_d   = ge ? diff[DataW-1:0] : shifted[DataW-1:0];
    quo_d   = {quo_q[DataW-2:0], ge};
    ovf_d   = ovf_q | quo_q[DataW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0;
    end else if (ctrl_i.load) begin
      ovf_q <= 1'b0;
    end else if (ctrl_i.step) begin
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      divisor_q <= divisor_i;
      rem_q     <= '0;
      quo_q     <= '0;
    end else if (ctrl_i.step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = ovf_q ? '1 : quo_q;

endmodule

[hdl/wps_best_sel.sv]
module wps_best_sel (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  wps_pkg::sel_ctrl_t          ctrl_i,
  input  logic [wps_pkg::DataW-1:0]   target_i,
  input  logic [wps_pkg::DataW-1:0]   timeout_i,
  output logic                        have_o,
  output logic [wps_pkg::DataW-1:0]   best_ms_o,
  output logic [wps_pkg::OrderW-1:0]  best_order_o
);
  import wps_pkg::*;

  logic              have_q;
  logic [DataW-1:0]  best_ms_q;
  logic [OrderW-1:0] best_order_q;
  logic              better;

  // Equal timeouts from different shifts keep the pair earlier in search order.
  assign better = (timeout_i >= target_i) &&
                  (!have_q || (timeout_i < best_ms_q) ||
                   ((timeout_i == best_ms_q) && (ctrl_i.order < best_order_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      have_q <= 1'b0;
    end else if (ctrl_i.check && better) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.check && better) begin
      best_ms_q    <= timeout_i;
      best_order_q <= ctrl_i.order;
    end
  end

  assign have_o       = have_q;
  assign best_ms_o    = best_ms_q;
  assign best_order_o = best_order_q;

endmodule

[hdl/watchdog_prescaler_search.sv]
// Each accepted transaction starts one search; its result is registered into the
// output when the output register is free. The shared divider takes one numerator
// bit per cycle over 39 bits, and one divider and period pair per distinct shift
// is scored on the way. Input is not ready while a search runs or its result waits.
// Reset: asynchronous, active low; clears the sequencer and output valid.
module watchdog_prescaler_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] target_ms, [63:32] clock_hz
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [0] found, [14:1] divider, [31:15] period,
                                      // [63:32] actual_ms
);
  import wps_pkg::*;
  `include "watchdog_prescaler_search_defines.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  localparam logic [StepW-1:0] LastStep  = StepW'(NumBits);
  localparam logic [StepW-1:0] FirstScan = StepW'(MsW);

  state_e            state_q;
  logic [StepW-1:0]  step_q;
  logic              zero_q;
  logic [DataW-1:0]  target_q;
  logic              accept;
  logic              out_free;
  div_ctrl_t         div_ctrl;
  sel_ctrl_t         sel_ctrl;
  logic [DataW-1:0]  quotient;
  logic [ShiftW-1:0] shift;
  pair_hit_t         hit;
  logic              have;
  logic [DataW-1:0]  best_ms;
  logic [OrderW-1:0] best_order;
  logic [3:0]        ms_idx;

  logic                m_tvalid_q;
  logic                found_q;
  logic [DividerW-1:0] divider_q;
  logic [PeriodW-1:0]  period_q;
  logic [DataW-1:0]    actual_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_tvalid_q || m_axis_tready;

  // After step_q steps, the quotient register holds the timeout for a
  // numerator of 1000 shifted by step_q minus ten.
  assign shift  = ShiftW'(step_q - FirstScan);
  assign hit    = first_pair(shift);
  assign ms_idx = 4'(MsW - 1) - step_q[3:0];

  always_comb begin
    div_ctrl.load    = accept;
    div_ctrl.step    = (state_q == ST_RUN) && (step_q < LastStep);
    div_ctrl.num_bit = (step_q < FirstScan) ? MsPerSecond[ms_idx] : 1'b0;
    sel_ctrl.clear   = accept;
    sel_ctrl.check   = (state_q == ST_RUN) && (step_q >= FirstScan) && hit.hit && !zero_q;
    sel_ctrl.order   = hit.order;
  end

  wps_div_unit u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (div_ctrl),
    .divisor_i  (s_axis_tdata[63:32]),
    .quotient_o (quotient)
  );

  wps_best_sel u_sel (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (sel_ctrl),
    .target_i     (target_q),
    .timeout_i    (quotient),
    .have_o       (have),
    .best_ms_o    (best_ms),
    .best_order_o (best_order)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      step_q     <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      if (state_q == ST_FINISH && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            step_q  <= '0;
            state_q <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (step_q == LastStep) begin
            state_q <= ST_FINISH;
          end else begin
            step_q <= step_q + StepW'(1);
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      target_q <= s_axis_tdata[31:0];
      zero_q   <= (s_axis_tdata[63:32] == '0);
    end
    if (state_q == ST_FINISH && out_free) begin
      found_q   <= have;
      divider_q <= have ? divider_of(best_order) : '0;
      period_q  <= have ? period_of(best_order) : '0;
      actual_q  <= have ? best_ms : '0;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = {actual_q, period_q, divider_q, found_q};

  `WPS_ASSERT_NOW(a_busy_not_ready, state_q != ST_IDLE, !s_axis_tready,
    "input ready while a search runs")
  `WPS_ASSERT_NOW(a_step_bound, state_q == ST_RUN, step_q <= LastStep,
    "step counter past the last numerator bit")
  `WPS_ASSERT_NOW(a_not_found_zero, m_axis_tvalid && !found_q,
    divider_q == '0 && period_q == '0 && actual_q == '0,
    "nonzero result fields without a solution")
  `WPS_ASSERT_NOW(a_found_fields, m_axis_tvalid && found_q,
    $onehot(divider_q) && $onehot(period_q), "found result with a bad pair")
  `WPS_ASSERT_NEXT(a_accept_starts, accept, state_q == ST_RUN && step_q == '0,
    "accepted transaction did not start a search")

endmodule
